// File: hdl/tcpfsm_pkg.sv
// Shared types, codes and constants for the single-connection TCP state machine.
`default_nettype none

package tcpfsm_pkg;

    typedef enum logic [2:0] {
        ST_LISTEN      = 3'd0,
        ST_SYN_RCVD    = 3'd1,
        ST_ESTABLISHED = 3'd2,
        ST_FIN_WAIT_1  = 3'd3,
        ST_FIN_WAIT_2  = 3'd4,
        ST_CLOSED      = 3'd5
    } conn_state_t;

    typedef enum logic [1:0] {
        KIND_SEGMENT = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACT_NOTHING = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_DELIVER = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    localparam logic CFG_ACCEPT_PORT = 1'b0;
    localparam logic CFG_INITIAL_SEQ = 1'b1;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [15:0] MAX_WRITE    = 16'd1460;
    localparam logic [6:0]  IP_HDR_BYTES = 7'd20;
    localparam logic [31:0] INITIAL_SEQ_RESET = 32'd1000;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] src_ip;
        logic [15:0] seg_sport;
        logic [15:0] seg_dport;
        logic [7:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [15:0] ip_total_length;
        logic [3:0]  hdr_words;
        logic [15:0] write_length;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] ip;
        logic [15:0] pport;
        logic [15:0] oport;
        logic [15:0] len;
        logic        rejected;
        logic        last;
    } result_t;

    function automatic result_t mk_result(
        input action_t     action,
        input logic [7:0]  flags,
        input logic [31:0] seq,
        input logic [31:0] ack,
        input logic [31:0] ip,
        input logic [15:0] pport,
        input logic [15:0] oport,
        input logic [15:0] len,
        input logic        rejected
    );
        result_t r;
        r.action   = action;
        r.flags    = flags;
        r.seq      = seq;
        r.ack      = ack;
        r.ip       = ip;
        r.pport    = pport;
        r.oport    = oport;
        r.len      = len;
        r.rejected = rejected;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tcp_single_connection_fsm.sv
// Top level of the passive single-connection TCP state machine.
// An item is registered in the stage register, then its results in the result queue.
// Throughput: one item per cycle while each item yields at most one result and results
// are taken every cycle; an item with several results holds the queue until all are taken.
// Reset clears the connection state to listen, all sequence and peer registers to
// zero, the accept port to zero and initial_seq to 1000; both stages come up empty.
`default_nettype none

module tcp_single_connection_fsm
    import tcpfsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] src_ip,
    input  wire logic [15:0] seg_sport,
    input  wire logic [15:0] seg_dport,
    input  wire logic [7:0]  seg_flags,
    input  wire logic [31:0] seg_seq,
    input  wire logic [15:0] ip_total_length,
    input  wire logic [3:0]  hdr_words,
    input  wire logic [15:0] write_length,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       action,
    output logic [7:0]       out_flags,
    output logic [31:0]      out_seq,
    output logic [31:0]      out_ack,
    output logic [31:0]      peer_ip,
    output logic [15:0]      peer_port,
    output logic [15:0]      own_port,
    output logic [15:0]      length,
    output logic             write_rejected,
    output logic             last
);

    logic [15:0]  accept_port_reg;
    logic [31:0]  initial_seq_reg;

    conn_state_t  state_reg, state_next;
    logic [31:0]  raddr_reg, raddr_next;
    logic [15:0]  rport_reg, rport_next;
    logic [15:0]  lport_reg, lport_next;
    logic [31:0]  snd_reg, snd_next;
    logic [31:0]  rcv_reg, rcv_next;

    logic         stg_valid_reg;
    item_t        stg_reg;

    result_t      res_reg [3];
    logic [1:0]   cnt_reg;

    result_t      res_c [3];
    logic [1:0]   n_res;

    logic         advance;
    logic         buf_free;
    logic         pop;
    logic         cfg_write;

    logic [6:0]   hdr_len;
    logic [15:0]  plen;
    logic         match;
    logic [31:0]  seq_plus_plen;
    logic [31:0]  seq_plus_one;
    logic [31:0]  fin_ack_est;
    logic [15:0]  wlen;
    logic         is_syn_hit;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid & cfg_ready;

    assign pop        = result_valid & result_ready;
    assign buf_free   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && result_ready);
    assign advance    = stg_valid_reg && ((n_res == 2'd0) || buf_free);
    assign item_ready = !stg_valid_reg || advance;

    assign hdr_len       = IP_HDR_BYTES + {1'b0, stg_reg.hdr_words, 2'b00};
    assign plen          = (stg_reg.ip_total_length > {9'd0, hdr_len})
                           ? (stg_reg.ip_total_length - {9'd0, hdr_len}) : 16'd0;
    assign match         = (stg_reg.src_ip == raddr_reg) && (stg_reg.seg_sport == rport_reg);
    assign seq_plus_plen = stg_reg.seg_seq + {16'd0, plen};
    assign seq_plus_one  = stg_reg.seg_seq + 32'd1;
    assign fin_ack_est   = seq_plus_plen + 32'd1;
    assign wlen          = (stg_reg.write_length > MAX_WRITE) ? MAX_WRITE
                                                               : stg_reg.write_length;
    assign is_syn_hit    = ((stg_reg.seg_flags & FL_SYN) != 8'd0)
                           && (stg_reg.seg_dport == accept_port_reg);

    always_comb
    begin
        state_next = state_reg;
        raddr_next = raddr_reg;
        rport_next = rport_reg;
        lport_next = lport_reg;
        snd_next   = snd_reg;
        rcv_next   = rcv_reg;
        case (stg_reg.kind)
            KIND_SEGMENT:
            begin
                if ((stg_reg.seg_flags & FL_RST) != 8'd0)
                begin
                    state_next = ST_LISTEN;
                end
                else
                begin
                    case (state_reg)
                        ST_SYN_RCVD:
                        begin
                            if (((stg_reg.seg_flags & FL_ACK) != 8'd0) && match)
                            begin
                                state_next = ST_ESTABLISHED;
                            end
                        end
                        ST_ESTABLISHED:
                        begin
                            if (match)
                            begin
                                if ((stg_reg.seg_flags & FL_FIN) != 8'd0)
                                begin
                                    rcv_next   = fin_ack_est;
                                    snd_next   = snd_reg + 32'd1;
                                    state_next = ST_CLOSED;
                                end
                                else if (plen != 16'd0)
                                begin
                                    rcv_next = seq_plus_plen;
                                end
                            end
                        end
                        ST_FIN_WAIT_1:
                        begin
                            if (match && ((stg_reg.seg_flags & FL_ACK) != 8'd0))
                            begin
                                if ((stg_reg.seg_flags & FL_FIN) != 8'd0)
                                begin
                                    rcv_next   = seq_plus_one;
                                    state_next = ST_CLOSED;
                                end
                                else
                                begin
                                    state_next = ST_FIN_WAIT_2;
                                end
                            end
                        end
                        ST_FIN_WAIT_2:
                        begin
                            if (match && ((stg_reg.seg_flags & FL_FIN) != 8'd0))
                            begin
                                rcv_next   = seq_plus_one;
                                state_next = ST_CLOSED;
                            end
                        end
                        ST_CLOSED:
                        begin
                            state_next = ST_LISTEN;
                        end
                        default:
                        begin
                            state_next = ST_LISTEN;
                            if (is_syn_hit)
                            begin
                                raddr_next = stg_reg.src_ip;
                                rport_next = stg_reg.seg_sport;
                                lport_next = stg_reg.seg_dport;
                                rcv_next   = seq_plus_one;
                                snd_next   = initial_seq_reg + 32'd1;
                                state_next = ST_SYN_RCVD;
                            end
                        end
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (state_reg == ST_ESTABLISHED)
                begin
                    snd_next = snd_reg + {16'd0, wlen};
                end
            end
            KIND_CLOSE:
            begin
                if (state_reg == ST_ESTABLISHED)
                begin
                    snd_next   = snd_reg + 32'd1;
                    state_next = ST_FIN_WAIT_1;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_comb
    begin
        res_c[0] = '0;
        res_c[1] = '0;
        res_c[2] = '0;
        n_res    = 2'd0;
        case (stg_reg.kind)
            KIND_SEGMENT:
            begin
                if ((stg_reg.seg_flags & FL_RST) == 8'd0)
                begin
                    case (state_reg)
                        ST_SYN_RCVD:
                        begin
                            n_res = 2'd0;
                        end
                        ST_ESTABLISHED:
                        begin
                            if (match)
                            begin
                                if ((stg_reg.seg_flags & FL_FIN) != 8'd0)
                                begin
                                    if (plen != 16'd0)
                                    begin
                                        res_c[0] = mk_result(ACT_DELIVER, 8'd0, 32'd0, 32'd0,
                                            stg_reg.src_ip, stg_reg.seg_sport,
                                            stg_reg.seg_dport, plen, 1'b0);
                                        res_c[1] = mk_result(ACT_SEND, FL_ACK, snd_reg,
                                            fin_ack_est, raddr_reg, rport_reg, lport_reg,
                                            16'd0, 1'b0);
                                        res_c[2] = mk_result(ACT_SEND, FL_FIN | FL_ACK,
                                            snd_reg, fin_ack_est, raddr_reg, rport_reg,
                                            lport_reg, 16'd0, 1'b0);
                                        n_res    = 2'd3;
                                    end
                                    else
                                    begin
                                        res_c[0] = mk_result(ACT_SEND, FL_ACK, snd_reg,
                                            fin_ack_est, raddr_reg, rport_reg, lport_reg,
                                            16'd0, 1'b0);
                                        res_c[1] = mk_result(ACT_SEND, FL_FIN | FL_ACK,
                                            snd_reg, fin_ack_est, raddr_reg, rport_reg,
                                            lport_reg, 16'd0, 1'b0);
                                        n_res    = 2'd2;
                                    end
                                end
                                else if (plen != 16'd0)
                                begin
                                    res_c[0] = mk_result(ACT_DELIVER, 8'd0, 32'd0, 32'd0,
                                        stg_reg.src_ip, stg_reg.seg_sport,
                                        stg_reg.seg_dport, plen, 1'b0);
                                    n_res    = 2'd1;
                                end
                            end
                        end
                        ST_FIN_WAIT_1:
                        begin
                            if (match && ((stg_reg.seg_flags & FL_ACK) != 8'd0)
                                && ((stg_reg.seg_flags & FL_FIN) != 8'd0))
                            begin
                                res_c[0] = mk_result(ACT_SEND, FL_ACK, snd_reg, seq_plus_one,
                                    raddr_reg, rport_reg, lport_reg, 16'd0, 1'b0);
                                n_res    = 2'd1;
                            end
                        end
                        ST_FIN_WAIT_2:
                        begin
                            if (match && ((stg_reg.seg_flags & FL_FIN) != 8'd0))
                            begin
                                res_c[0] = mk_result(ACT_SEND, FL_ACK, snd_reg, seq_plus_one,
                                    raddr_reg, rport_reg, lport_reg, 16'd0, 1'b0);
                                n_res    = 2'd1;
                            end
                        end
                        ST_CLOSED:
                        begin
                            n_res = 2'd0;
                        end
                        default:
                        begin
                            if (is_syn_hit)
                            begin
                                res_c[0] = mk_result(ACT_SEND, FL_SYN | FL_ACK,
                                    initial_seq_reg, seq_plus_one, stg_reg.src_ip,
                                    stg_reg.seg_sport, stg_reg.seg_dport, 16'd0, 1'b0);
                                n_res    = 2'd1;
                            end
                        end
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (state_reg == ST_ESTABLISHED)
                begin
                    res_c[0] = mk_result(ACT_SEND, FL_ACK | FL_PSH, snd_reg, rcv_reg,
                        raddr_reg, rport_reg, lport_reg, wlen, 1'b0);
                end
                else
                begin
                    res_c[0] = mk_result(ACT_NOTHING, 8'd0, 32'd0, 32'd0,
                        raddr_reg, rport_reg, lport_reg, 16'd0, 1'b1);
                end
                n_res = 2'd1;
            end
            KIND_CLOSE:
            begin
                if (state_reg == ST_ESTABLISHED)
                begin
                    res_c[0] = mk_result(ACT_SEND, FL_FIN | FL_ACK, snd_reg, rcv_reg,
                        raddr_reg, rport_reg, lport_reg, 16'd0, 1'b0);
                    n_res    = 2'd1;
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        case (n_res)
            2'd1:    res_c[0].last = 1'b1;
            2'd2:    res_c[1].last = 1'b1;
            2'd3:    res_c[2].last = 1'b1;
            default: res_c[0].last = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stg_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stg_reg.kind            <= kind_t'(kind);
            stg_reg.src_ip          <= src_ip;
            stg_reg.seg_sport       <= seg_sport;
            stg_reg.seg_dport       <= seg_dport;
            stg_reg.seg_flags       <= seg_flags;
            stg_reg.seg_seq         <= seg_seq;
            stg_reg.ip_total_length <= ip_total_length;
            stg_reg.hdr_words       <= hdr_words;
            stg_reg.write_length    <= write_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_port_reg <= 16'd0;
            initial_seq_reg <= INITIAL_SEQ_RESET;
            state_reg       <= ST_LISTEN;
            raddr_reg       <= 32'd0;
            rport_reg       <= 16'd0;
            lport_reg       <= 16'd0;
            snd_reg         <= 32'd0;
            rcv_reg         <= 32'd0;
        end
        else
        begin
            if (advance)
            begin
                raddr_reg <= raddr_next;
                rport_reg <= rport_next;
                lport_reg <= lport_next;
                snd_reg   <= snd_next;
                rcv_reg   <= rcv_next;
            end
            if (cfg_write && (cfg_index == CFG_ACCEPT_PORT))
            begin
                state_reg <= ST_LISTEN;
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ACCEPT_PORT:
                    begin
                        accept_port_reg <= cfg_data[15:0];
                    end
                    CFG_INITIAL_SEQ:
                    begin
                        initial_seq_reg <= cfg_data;
                    end
                    default:
                    begin
                        initial_seq_reg <= initial_seq_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (advance && (n_res != 2'd0))
        begin
            cnt_reg <= n_res;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (n_res != 2'd0))
        begin
            res_reg[0] <= res_c[0];
            res_reg[1] <= res_c[1];
            res_reg[2] <= res_c[2];
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign result_valid   = (cnt_reg != 2'd0);
    assign action         = res_reg[0].action;
    assign out_flags      = res_reg[0].flags;
    assign out_seq        = res_reg[0].seq;
    assign out_ack        = res_reg[0].ack;
    assign peer_ip        = res_reg[0].ip;
    assign peer_port      = res_reg[0].pport;
    assign own_port       = res_reg[0].oport;
    assign length         = res_reg[0].len;
    assign write_rejected = res_reg[0].rejected;
    assign last           = res_reg[0].last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3 || !res_reg[0].last)
        else $error("Result queue head marked last while more results are queued.");

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> res_reg[0].last)
        else $error("Only queued result is not marked last.");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !res_reg[0].last) |=> result_valid)
        else $error("Result sequence ended without a last beat.");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && !cfg_write) |=> (state_reg == $past(state_reg)))
        else $error("Connection state changed without an item or a register write.");

endmodule

`default_nettype wire

// File: test/tcp_single_connection_fsm_tb.sv
// Self-checking testbench for the single-connection TCP state machine with its own TCB predictor.
`timescale 1ns / 1ps

module tcp_single_connection_fsm_tb;
    import tcpfsm_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic        clk;
    logic        rst_n;

    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    logic        item_valid;
    logic        item_ready;
    logic [1:0]  kind;
    logic [31:0] src_ip;
    logic [15:0] seg_sport;
    logic [15:0] seg_dport;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [15:0] ip_total_length;
    logic [3:0]  hdr_words;
    logic [15:0] write_length;

    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  action;
    logic [7:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [15:0] length;
    logic        write_rejected;
    logic        last;

    int unsigned send_idle_pct  = 33;
    int unsigned recv_stall_pct = 53;
    int unsigned items_sent     = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // Transmission control block as the testbench tracks it.
    conn_state_t tcb_state       = ST_LISTEN;
    logic [31:0] tcb_peer_ip     = '0;
    logic [15:0] tcb_peer_port   = '0;
    logic [15:0] tcb_own_port    = '0;
    logic [31:0] tcb_snd_nxt     = '0;
    logic [31:0] tcb_rcv_nxt     = '0;
    logic [15:0] tcb_accept_port = '0;
    logic [31:0] tcb_iss         = INITIAL_SEQ_RESET;

    result_t fsm_answers[$];
    result_t want_r;
    result_t got_r;

    tcp_single_connection_fsm dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .kind            (kind),
        .src_ip          (src_ip),
        .seg_sport       (seg_sport),
        .seg_dport       (seg_dport),
        .seg_flags       (seg_flags),
        .seg_seq         (seg_seq),
        .ip_total_length (ip_total_length),
        .hdr_words       (hdr_words),
        .write_length    (write_length),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .action          (action),
        .out_flags       (out_flags),
        .out_seq         (out_seq),
        .out_ack         (out_ack),
        .peer_ip         (peer_ip),
        .peer_port       (peer_port),
        .own_port        (own_port),
        .length          (length),
        .write_rejected  (write_rejected),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic string show(input result_t r);
        return {$sformatf("act=%0d flags=%h seq=%h ack=%h ip=%h",
                          r.action, r.flags, r.seq, r.ack, r.ip),
                $sformatf(" pport=%h oport=%h len=%0d rej=%0d last=%0d",
                          r.pport, r.oport, r.len, r.rejected, r.last)};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            got_r.action   = action_t'(action);
            got_r.flags    = out_flags;
            got_r.seq      = out_seq;
            got_r.ack      = out_ack;
            got_r.ip       = peer_ip;
            got_r.pport    = peer_port;
            got_r.oport    = own_port;
            got_r.len      = length;
            got_r.rejected = write_rejected;
            got_r.last     = last;
            if (fsm_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat: expected none, actual %s", $time,
                         show(got_r));
            end
            else
            begin
                want_r = fsm_answers.pop_front();
                if (got_r !== want_r)
                begin
                    mismatches++;
                    $display("%0t: expected %s, actual %s", $time, show(want_r),
                             show(got_r));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tcp_single_connection_fsm: mismatch");
        $finish;
    end

    task automatic queue_segment(input logic [7:0] fl, input logic [15:0] len);
        result_t r;
        r          = '0;
        r.action   = ACT_SEND;
        r.flags    = fl;
        r.seq      = tcb_snd_nxt;
        r.ack      = tcb_rcv_nxt;
        r.ip       = tcb_peer_ip;
        r.pport    = tcb_peer_port;
        r.oport    = tcb_own_port;
        r.len      = len;
        fsm_answers.push_back(r);
        tcb_snd_nxt = tcb_snd_nxt + len + ((fl & FL_SYN) != 0) + ((fl & FL_FIN) != 0);
    endtask

    task automatic track_connection(input item_t it);
        int unsigned hdr_bytes;
        int unsigned plen;
        int unsigned first;
        logic        peer_match;
        logic        has_ack;
        logic        has_fin;
        result_t     r;
        first      = fsm_answers.size();
        hdr_bytes  = IP_HDR_BYTES + 4 * it.hdr_words;
        plen       = (it.ip_total_length > hdr_bytes) ? it.ip_total_length - hdr_bytes : 0;
        peer_match = (it.src_ip == tcb_peer_ip) && (it.seg_sport == tcb_peer_port);
        has_ack    = (it.seg_flags & FL_ACK) != 0;
        has_fin    = (it.seg_flags & FL_FIN) != 0;
        case (it.kind)
            KIND_SEGMENT:
            begin
                if ((it.seg_flags & FL_RST) != 0)
                    tcb_state = ST_LISTEN;
                else
                begin
                    case (tcb_state)
                        ST_SYN_RCVD:
                        begin
                            if (has_ack && peer_match)
                                tcb_state = ST_ESTABLISHED;
                        end
                        ST_ESTABLISHED:
                        begin
                            if (peer_match)
                            begin
                                if (plen > 0)
                                begin
                                    tcb_rcv_nxt = it.seg_seq + plen;
                                    r           = '0;
                                    r.action    = ACT_DELIVER;
                                    r.ip        = it.src_ip;
                                    r.pport     = it.seg_sport;
                                    r.oport     = it.seg_dport;
                                    r.len       = 16'(plen);
                                    fsm_answers.push_back(r);
                                end
                                if (has_fin)
                                begin
                                    tcb_rcv_nxt = it.seg_seq + plen + 1;
                                    queue_segment(FL_ACK, 16'd0);
                                    queue_segment(FL_FIN | FL_ACK, 16'd0);
                                    tcb_state = ST_CLOSED;
                                end
                            end
                        end
                        ST_FIN_WAIT_1:
                        begin
                            if (peer_match && has_ack)
                            begin
                                if (has_fin)
                                begin
                                    tcb_rcv_nxt = it.seg_seq + 1;
                                    queue_segment(FL_ACK, 16'd0);
                                    tcb_state = ST_CLOSED;
                                end
                                else
                                    tcb_state = ST_FIN_WAIT_2;
                            end
                        end
                        ST_FIN_WAIT_2:
                        begin
                            if (peer_match && has_fin)
                            begin
                                tcb_rcv_nxt = it.seg_seq + 1;
                                queue_segment(FL_ACK, 16'd0);
                                tcb_state = ST_CLOSED;
                            end
                        end
                        ST_CLOSED:
                            tcb_state = ST_LISTEN;
                        default:
                        begin
                            tcb_state = ST_LISTEN;
                            if ((it.seg_flags & FL_SYN) != 0 && it.seg_dport == tcb_accept_port)
                            begin
                                tcb_peer_ip   = it.src_ip;
                                tcb_peer_port = it.seg_sport;
                                tcb_own_port  = it.seg_dport;
                                tcb_rcv_nxt   = it.seg_seq + 1;
                                tcb_snd_nxt   = tcb_iss;
                                queue_segment(FL_SYN | FL_ACK, 16'd0);
                                tcb_state = ST_SYN_RCVD;
                            end
                        end
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (tcb_state == ST_ESTABLISHED)
                    queue_segment(FL_ACK | FL_PSH,
                                  (it.write_length > MAX_WRITE) ? MAX_WRITE : it.write_length);
                else
                begin
                    r          = '0;
                    r.action   = ACT_NOTHING;
                    r.ip       = tcb_peer_ip;
                    r.pport    = tcb_peer_port;
                    r.oport    = tcb_own_port;
                    r.rejected = 1'b1;
                    fsm_answers.push_back(r);
                end
            end
            KIND_CLOSE:
            begin
                if (tcb_state == ST_ESTABLISHED)
                begin
                    queue_segment(FL_FIN | FL_ACK, 16'd0);
                    tcb_state = ST_FIN_WAIT_1;
                end
            end
            default:
            begin
            end
        endcase
        if (fsm_answers.size() > first)
        begin
            r      = fsm_answers.pop_back();
            r.last = 1'b1;
            fsm_answers.push_back(r);
        end
    endtask

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid      <= 1'b1;
        kind            <= it.kind;
        src_ip          <= it.src_ip;
        seg_sport       <= it.seg_sport;
        seg_dport       <= it.seg_dport;
        seg_flags       <= it.seg_flags;
        seg_seq         <= it.seg_seq;
        ip_total_length <= it.ip_total_length;
        hdr_words       <= it.hdr_words;
        write_length    <= it.write_length;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        track_connection(it);
        items_sent++;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (fsm_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ACCEPT_PORT)
        begin
            tcb_accept_port = val[15:0];
            tcb_state       = ST_LISTEN;
        end
        else
            tcb_iss = val;
    endtask

    function automatic item_t raw_seg(input logic [31:0] ip, input logic [15:0] sp,
                                      input logic [15:0] dp, input logic [7:0] fl,
                                      input logic [31:0] sq, input logic [15:0] total,
                                      input logic [3:0] off);
        item_t it;
        it.kind            = KIND_SEGMENT;
        it.src_ip          = ip;
        it.seg_sport       = sp;
        it.seg_dport       = dp;
        it.seg_flags       = fl;
        it.seg_seq         = sq;
        it.ip_total_length = total;
        it.hdr_words       = off;
        it.write_length    = 16'($urandom);
        return it;
    endfunction

    function automatic item_t seg(input logic [31:0] ip, input logic [15:0] sp,
                                  input logic [15:0] dp, input logic [7:0] fl,
                                  input logic [31:0] sq, input int unsigned plen);
        logic [3:0] off;
        off = 4'($urandom_range(15));
        return raw_seg(ip, sp, dp, fl, sq, 16'(IP_HDR_BYTES + 4 * off + plen), off);
    endfunction

    function automatic item_t app_item(input kind_t k, input logic [15:0] wl);
        item_t it;
        it              = raw_seg($urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                                  $urandom, 16'($urandom), 4'($urandom));
        it.kind         = k;
        it.write_length = wl;
        return it;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it      = app_item(KIND_SEGMENT, 16'($urandom));
        it.kind = kind_t'($urandom_range(3));
        return it;
    endfunction

    function automatic logic [7:0] extra_flags();
        return 8'($urandom) & ~(FL_FIN | FL_SYN | FL_RST | FL_ACK);
    endfunction

    function automatic int unsigned random_payload();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(1461, 65455);
            default: return $urandom_range(1, 1460);
        endcase
    endfunction

    function automatic logic [15:0] random_write_len();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return MAX_WRITE;
            2, 3, 4: return 16'($urandom_range(MAX_WRITE + 1, 65535));
            default: return 16'($urandom_range(1, MAX_WRITE));
        endcase
    endfunction

    task automatic test_idle_requests();
        send_item(app_item(KIND_WRITE, 16'hFFFF));
        send_item(app_item(KIND_CLOSE, 16'h0000));
        send_item(app_item(KIND_NONE, 16'h0000));
    endtask

    task automatic test_handshake_and_data();
        logic [31:0] ip;
        logic [15:0] sp;
        ip = 32'hFFFF_FFFF;
        sp = 16'hFFFF;
        send_item(raw_seg(ip, sp, 16'h0000, FL_SYN, 32'hFFFF_FFFF, 16'd20, 4'd0));
        send_item(raw_seg(ip, sp, 16'h0000, FL_ACK, 32'h0000_0000, 16'd40, 4'd5));
        send_item(raw_seg(ip, sp, 16'h0000, FL_PSH | FL_ACK, 32'h0000_0000, 16'hFFFF, 4'd0));
        send_item(raw_seg(ip, sp, 16'h0000, FL_ACK, 32'h0000_FFEB, 16'd10, 4'd15));
        send_item(app_item(KIND_WRITE, 16'h0000));
        send_item(app_item(KIND_WRITE, 16'hFFFF));
        send_item(app_item(KIND_WRITE, MAX_WRITE));
        send_item(seg(ip, 16'hFFFE, 16'h0000, FL_PSH | FL_ACK, 32'h0000_FFEB, 200));
        send_item(app_item(KIND_CLOSE, 16'h0000));
        send_item(app_item(KIND_WRITE, 16'd100));
        send_item(seg(ip, sp, 16'h0000, FL_ACK, 32'h0000_FFEB, 0));
        send_item(seg(ip, sp, 16'h0000, FL_FIN, 32'h0000_FFEB, 0));
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_ACCEPT_PORT, 32'h0000_FFFF);
        write_reg(CFG_INITIAL_SEQ, 32'hFFFF_FFFF);
        send_item(seg(32'h0, 16'h0, 16'h0000, FL_SYN, 32'h7FFF_FFFF, 0));
        send_item(seg(32'h0, 16'h0, 16'hFFFF, FL_SYN, 32'h7FFF_FFFF, 0));
        send_item(seg(32'h0, 16'h0, 16'hFFFF, FL_ACK, 32'h8000_0000, 0));
        send_item(seg(32'h0, 16'h0, 16'hFFFF, FL_FIN | FL_PSH | FL_ACK, 32'h8000_0000, 100));
        send_item(seg(32'h0, 16'h0, 16'hFFFF, FL_ACK, 32'h8000_0065, 0));
    endtask

    task automatic test_crossed_close_and_resets();
        logic [31:0] ip;
        logic [15:0] sp;
        ip = 32'h0A00_0001;
        sp = 16'h8000;
        write_reg(CFG_INITIAL_SEQ, 32'h0000_0000);
        send_item(seg(ip, sp, tcb_accept_port, FL_SYN, 32'h1234_5678, 0));
        send_item(seg(ip, sp, tcb_accept_port, FL_ACK, 32'h1234_5679, 0));
        send_item(app_item(KIND_CLOSE, 16'h0000));
        send_item(seg(ip, sp, tcb_accept_port, FL_FIN | FL_ACK, 32'h1234_5679, 0));
        send_item(seg(ip, sp, tcb_accept_port, FL_RST | FL_SYN, 32'h1234_567A, 0));
        send_item(seg(ip, sp, tcb_accept_port, FL_SYN, 32'h0000_0000, 0));
        send_item(seg(ip, sp, tcb_accept_port, 8'hFF, 32'h0000_0001, 0));
        send_item(app_item(KIND_WRITE, 16'd10));
    endtask

    task automatic random_session();
        logic [31:0] ip;
        logic [31:0] sq;
        logic [31:0] fip;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] fsp;
        int unsigned plen;
        ip = $urandom;
        sp = 16'($urandom);
        sq = $urandom;
        dp = ($urandom_range(9) == 0) ? 16'($urandom) : tcb_accept_port;
        send_item(seg(ip, sp, dp, FL_SYN | extra_flags() | ($urandom_range(1) ? FL_ACK : 8'h00),
                      sq, 0));
        sq = sq + 1;
        send_item(seg(ip, sp, dp, FL_ACK | extra_flags(), sq, 0));
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    plen = random_payload();
                    send_item(seg(ip, sp, dp, FL_ACK | extra_flags(), sq, plen));
                    sq = sq + plen;
                end
                4, 5, 6:
                    send_item(app_item(KIND_WRITE, random_write_len()));
                7:
                begin
                    fip = ip;
                    fsp = sp;
                    if ($urandom_range(1))
                        fip = ip ^ (32'd1 << $urandom_range(31));
                    else
                        fsp = sp ^ (16'd1 << $urandom_range(15));
                    send_item(seg(fip, fsp, dp, FL_FIN | FL_ACK, sq, random_payload()));
                end
                8:
                    send_item(noise_item());
                default:
                    send_item(seg(ip, sp, dp, FL_ACK, sq, 0));
            endcase
        end
        case ($urandom_range(5))
            0, 1:
            begin
                plen = $urandom_range(1) ? random_payload() : 0;
                send_item(seg(ip, sp, dp, FL_FIN | FL_ACK | extra_flags(), sq, plen));
            end
            2:
            begin
                send_item(app_item(KIND_CLOSE, 16'($urandom)));
                send_item(seg(ip, sp, dp, FL_ACK, sq, 0));
                send_item(seg(ip, sp, dp, FL_FIN | ($urandom_range(1) ? FL_ACK : 8'h00), sq, 0));
            end
            3:
            begin
                send_item(app_item(KIND_CLOSE, 16'($urandom)));
                send_item(seg(ip, sp, dp, FL_FIN | FL_ACK, sq, 0));
            end
            4:
                send_item(seg(ip, sp, dp, FL_RST | 8'($urandom), sq, 0));
            default:
            begin
            end
        endcase
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                       input int unsigned n_items, input logic [15:0] port,
                                       input logic [31:0] iss);
        int unsigned goal;
        write_reg(CFG_ACCEPT_PORT, {16'($urandom), port});
        write_reg(CFG_INITIAL_SEQ, iss);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        goal           = items_sent + n_items;
        while (items_sent < goal)
        begin
            if ($urandom_range(9) == 0)
                send_item(noise_item());
            else
                random_session();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_ACCEPT_PORT;
        cfg_data        <= '0;
        item_valid      <= 1'b0;
        kind            <= KIND_SEGMENT;
        src_ip          <= '0;
        seg_sport       <= '0;
        seg_dport       <= '0;
        seg_flags       <= '0;
        seg_seq         <= '0;
        ip_total_length <= '0;
        hdr_words       <= '0;
        write_length    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_requests();
        test_handshake_and_data();
        test_config_extremes();
        test_crossed_close_and_resets();
        test_random_traffic(33, 53, 125, 16'($urandom), $urandom);
        test_random_traffic(53, 33, 125, 16'($urandom), 32'hFFFF_FF00 | $urandom_range(255));
        test_random_traffic(0, 0, 125, 16'h0000, $urandom);

        settle();
        if (mismatches == 0)
            $display("tcp_single_connection_fsm: match");
        else
            $display("tcp_single_connection_fsm: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hdl/tcpfsm_pkg.sv
hdl/tcp_single_connection_fsm.sv
test/tcp_single_connection_fsm_tb.sv
